// ----- rtl/wavhp_pkg.sv -----
// wavhp_pkg: shared types, tags and codes for the wav header parser
// no dependencies; used by every module under rtl
`timescale 1ns / 1ps

package wavhp_pkg;

    // chunk tags as they appear big-endian in the shift register
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // result kinds
    typedef enum logic [1:0] {
        EV_FORMAT = 2'd0,
        EV_DATA   = 2'd1,
        EV_ERROR  = 2'd2
    } event_kind_t;

    // error codes
    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_NO_RIFF   = 4'd1,
        ERR_NO_WAVE   = 4'd2,
        ERR_NO_FMT    = 4'd3,
        ERR_ZERO_CHK  = 4'd4,
        ERR_NOT_PCM   = 4'd5,
        ERR_CHANNELS  = 4'd6,
        ERR_BITS      = 4'd7,
        ERR_NO_DATA   = 4'd8,
        ERR_ZERO_DATA = 4'd9,
        ERR_TRUNC     = 4'd10
    } error_code_t;

    // one result item plus its presence flag
    typedef struct packed {
        logic        has;
        event_kind_t kind;
        logic [31:0] sample_rate;
        logic        stereo;
        logic        sixteen_bit;
        logic [31:0] payload_length;
        logic [7:0]  data_byte;
        logic        end_of_run;
        error_code_t code;
    } result_t;

    // handshake status between the stages
    typedef struct packed {
        logic load;
        logic advance;
    } stage_ctl_t;

endpackage

// ----- rtl/wav_header_parser.sv -----
// wav_header_parser: top level, input register, parse core and result register
// depends on wavhp_pkg, wavhp_in_stage, wavhp_core, wavhp_out_stage
`timescale 1ns / 1ps

// Byte-stream RIFF/WAVE PCM header parser. One byte item is accepted per
// cycle whenever the input register is free or moving on; each item passes
// through an input register, combinational parse logic against small state
// registers, and a result register; the sustained rate is one byte per
// cycle while the result register is not held by out_stall. At most one
// result follows each byte: a format result when the data chunk header
// completes, one result per payload byte, or an error; bytes that produce no
// result never wait on the output side. A byte flagged buffer_end restarts
// the parser, replacing any other result with a truncation error if the parse
// was unfinished. No clearing pass is needed after reset.
module wav_header_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    input  logic        buffer_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_kind,
    output logic [31:0] sample_rate,
    output logic        stereo,
    output logic        sixteen_bit,
    output logic [31:0] payload_length,
    output logic [7:0]  data_byte,
    output logic        end_of_run,
    output logic [3:0]  error_code
);

    wavhp_pkg::stage_ctl_t ctl;
    wavhp_pkg::result_t    res;
    wavhp_pkg::result_t    held;
    logic                  s1_valid;
    logic [7:0]            s1_byte;
    logic                  s1_last;
    logic                  can_take;

    // item moves on when it has no result or the result register is free
    assign ctl.advance = s1_valid && (can_take || !res.has);
    assign in_stall    = s1_valid && !ctl.advance;
    assign ctl.load    = in_valid && !in_stall;

    wavhp_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .byte_in    (byte_in),
        .buffer_end (buffer_end),
        .s1_valid   (s1_valid),
        .s1_byte    (s1_byte),
        .s1_last    (s1_last)
    );

    wavhp_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (ctl.advance),
        .byte_in (s1_byte),
        .last    (s1_last),
        .res     (res)
    );

    wavhp_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ctl.advance && res.has),
        .res       (res),
        .out_stall (out_stall),
        .can_take  (can_take),
        .out_valid (out_valid),
        .held      (held)
    );

    // result fields
    assign event_kind     = held.kind;
    assign sample_rate    = held.sample_rate;
    assign stereo         = held.stereo;
    assign sixteen_bit    = held.sixteen_bit;
    assign payload_length = held.payload_length;
    assign data_byte      = held.data_byte;
    assign end_of_run     = held.end_of_run;
    assign error_code     = held.code;

endmodule

// ----- rtl/wavhp_in_stage.sv -----
// wavhp_in_stage: input register holding one accepted byte item
// depends on wavhp_pkg (stage_ctl_t)
`timescale 1ns / 1ps

module wavhp_in_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  wavhp_pkg::stage_ctl_t ctl,
    input  logic [7:0]            byte_in,
    input  logic                  buffer_end,
    output logic                  s1_valid,
    output logic [7:0]            s1_byte,
    output logic                  s1_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    // occupancy of the input register
    always_comb
    begin
        if (ctl.load)
        begin
            valid_next = 1'b1;
        end
        else if (ctl.advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            byte_reg <= byte_in;
            last_reg <= buffer_end;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_byte  = byte_reg;
    assign s1_last  = last_reg;

    // a held item keeps its byte until it moves on
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !ctl.advance |=> valid_reg && $stable(byte_reg) && $stable(last_reg))
        else $error("input register lost a held item");

endmodule

// ----- rtl/wavhp_core.sv -----
// wavhp_core: parse state registers and the per-byte next-state and result logic
// depends on wavhp_pkg (tags, codes, result_t)
`timescale 1ns / 1ps

module wavhp_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [7:0]         byte_in,
    input  logic               last,
    output wavhp_pkg::result_t res
);

    typedef enum logic [8:0] {
        PH_HEAD      = 9'b000000001,
        PH_FMT_HDR   = 9'b000000010,
        PH_FMT_SKIP  = 9'b000000100,
        PH_FMT_BODY  = 9'b000001000,
        PH_FMT_EXTRA = 9'b000010000,
        PH_DATA_HDR  = 9'b000100000,
        PH_DATA_SKIP = 9'b001000000,
        PH_DATA      = 9'b010000000,
        PH_IDLE      = 9'b100000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] fld_reg, fld_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] rate_reg, rate_next;
    logic        stereo_reg, stereo_next;
    logic        sixteen_reg, sixteen_next;

    logic [31:0] hdr_tag;
    logic [31:0] hdr_fld;
    logic        hdr_done;
    logic [4:0]  hdr_cnt;
    logic [31:0] rem_dec;
    logic        skip_done;
    logic [15:0] fmt_word;
    logic [15:0] ch_word;
    logic [15:0] bits_word;
    wavhp_pkg::error_code_t trunc_code;

    // chunk header assembly: tag big-endian, size little-endian
    always_comb
    begin
        hdr_tag  = (cnt_reg < 5'd4) ? {tag_reg[23:0], byte_in} : tag_reg;
        hdr_fld  = (cnt_reg < 5'd4) ? fld_reg : {byte_in, fld_reg[31:8]};
        hdr_done = (cnt_reg >= 5'd7);
        hdr_cnt  = hdr_done ? 5'd0 : cnt_reg + 5'd1;
    end

    // countdown of skipped bytes
    always_comb
    begin
        rem_dec   = (rem_reg != 32'd0) ? rem_reg - 32'd1 : rem_reg;
        skip_done = (rem_dec == 32'd0);
    end

    // format fields once the 16-byte body is in
    assign fmt_word  = tag_reg[15:0];
    assign ch_word   = tag_reg[31:16];
    assign bits_word = {byte_in, fld_reg[31:24]};

    // per-byte parse step
    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        tag_next     = tag_reg;
        fld_next     = fld_reg;
        rem_next     = rem_reg;
        rate_next    = rate_reg;
        stereo_next  = stereo_reg;
        sixteen_next = sixteen_reg;
        res          = '0;
        trunc_code   = wavhp_pkg::ERR_NONE;

        unique case (phase_reg)
            PH_HEAD:
            begin
                tag_next = {tag_reg[23:0], byte_in};
                if (cnt_reg == 5'd3 && tag_next != wavhp_pkg::TAG_RIFF)
                begin
                    res.has    = 1'b1;
                    res.code   = wavhp_pkg::ERR_NO_RIFF;
                    phase_next = PH_IDLE;
                end
                else if (cnt_reg >= 5'd11)
                begin
                    cnt_next = 5'd0;
                    if (tag_next != wavhp_pkg::TAG_WAVE)
                    begin
                        res.has    = 1'b1;
                        res.code   = wavhp_pkg::ERR_NO_WAVE;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_FMT_HDR;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            PH_FMT_HDR:
            begin
                tag_next = hdr_tag;
                fld_next = hdr_fld;
                cnt_next = hdr_cnt;
                if (hdr_done)
                begin
                    rem_next = hdr_fld;
                    if (hdr_tag == wavhp_pkg::TAG_FMT)
                    begin
                        phase_next = PH_FMT_BODY;
                    end
                    else if (hdr_fld == 32'd0)
                    begin
                        res.has    = 1'b1;
                        res.code   = wavhp_pkg::ERR_ZERO_CHK;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_FMT_SKIP;
                    end
                end
            end
            PH_FMT_SKIP:
            begin
                rem_next = rem_dec;
                if (skip_done)
                begin
                    phase_next = PH_FMT_HDR;
                end
            end
            PH_FMT_BODY:
            begin
                // bytes 0-3 format/channels, 4-7 rate, 14-15 bits per sample
                if (cnt_reg < 5'd4)
                begin
                    tag_next = {byte_in, tag_reg[31:8]};
                end
                else if (cnt_reg < 5'd8 || cnt_reg >= 5'd14)
                begin
                    fld_next = {byte_in, fld_reg[31:8]};
                end
                if (cnt_reg == 5'd7)
                begin
                    rate_next = fld_next;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg >= 5'd15)
                begin
                    cnt_next = 5'd0;
                    if (fmt_word != 16'd1)
                    begin
                        res.has    = 1'b1;
                        res.code   = wavhp_pkg::ERR_NOT_PCM;
                        phase_next = PH_IDLE;
                    end
                    else if (ch_word != 16'd1 && ch_word != 16'd2)
                    begin
                        res.has    = 1'b1;
                        res.code   = wavhp_pkg::ERR_CHANNELS;
                        phase_next = PH_IDLE;
                    end
                    else if (bits_word != 16'd8 && bits_word != 16'd16)
                    begin
                        res.has    = 1'b1;
                        res.code   = wavhp_pkg::ERR_BITS;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        stereo_next  = (ch_word == 16'd2);
                        sixteen_next = (bits_word == 16'd16);
                        if (rem_reg > 32'd16)
                        begin
                            rem_next   = rem_reg - 32'd16;
                            phase_next = PH_FMT_EXTRA;
                        end
                        else
                        begin
                            rem_next   = 32'd0;
                            phase_next = PH_DATA_HDR;
                        end
                    end
                end
            end
            PH_FMT_EXTRA:
            begin
                rem_next = rem_dec;
                if (skip_done)
                begin
                    phase_next = PH_DATA_HDR;
                end
            end
            PH_DATA_HDR:
            begin
                tag_next = hdr_tag;
                fld_next = hdr_fld;
                cnt_next = hdr_cnt;
                if (hdr_done)
                begin
                    if (hdr_tag == wavhp_pkg::TAG_DATA)
                    begin
                        if (hdr_fld == 32'd0)
                        begin
                            res.has    = 1'b1;
                            res.code   = wavhp_pkg::ERR_ZERO_DATA;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            res.has            = 1'b1;
                            res.kind           = wavhp_pkg::EV_FORMAT;
                            res.sample_rate    = rate_reg;
                            res.stereo         = stereo_reg;
                            res.sixteen_bit    = sixteen_reg;
                            res.payload_length = hdr_fld;
                            rem_next           = hdr_fld;
                            phase_next         = PH_DATA;
                        end
                    end
                    else if (hdr_fld == 32'd0)
                    begin
                        res.has    = 1'b1;
                        res.code   = wavhp_pkg::ERR_ZERO_CHK;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        rem_next   = hdr_fld;
                        phase_next = PH_DATA_SKIP;
                    end
                end
            end
            PH_DATA_SKIP:
            begin
                rem_next = rem_dec;
                if (skip_done)
                begin
                    phase_next = PH_DATA_HDR;
                end
            end
            PH_DATA:
            begin
                res.has       = 1'b1;
                res.kind      = wavhp_pkg::EV_DATA;
                res.data_byte = byte_in;
                rem_next      = rem_dec;
                if (skip_done)
                begin
                    res.end_of_run = 1'b1;
                    phase_next     = PH_IDLE;
                end
            end
            default:
            begin
                // idle and any stray code: swallow bytes
            end
        endcase

        // any error result carries only its code and the end mark
        if (res.has && res.code != wavhp_pkg::ERR_NONE)
        begin
            res.kind       = wavhp_pkg::EV_ERROR;
            res.end_of_run = 1'b1;
        end

        // final buffer byte: flag an unfinished parse, then restart
        if (last)
        begin
            unique case (phase_next)
                PH_FMT_HDR, PH_FMT_SKIP:
                begin
                    trunc_code = wavhp_pkg::ERR_NO_FMT;
                end
                PH_DATA_HDR, PH_DATA_SKIP:
                begin
                    trunc_code = wavhp_pkg::ERR_NO_DATA;
                end
                PH_HEAD, PH_FMT_BODY, PH_FMT_EXTRA, PH_DATA:
                begin
                    trunc_code = wavhp_pkg::ERR_TRUNC;
                end
                default:
                begin
                    trunc_code = wavhp_pkg::ERR_NONE;
                end
            endcase
            if (trunc_code != wavhp_pkg::ERR_NONE)
            begin
                res            = '0;
                res.has        = 1'b1;
                res.kind       = wavhp_pkg::EV_ERROR;
                res.end_of_run = 1'b1;
                res.code       = trunc_code;
            end
            phase_next   = PH_HEAD;
            cnt_next     = 5'd0;
            tag_next     = 32'd0;
            fld_next     = 32'd0;
            rem_next     = 32'd0;
            rate_next    = 32'd0;
            stereo_next  = 1'b0;
            sixteen_next = 1'b0;
        end
    end

    // state update on each committed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEAD;
            cnt_reg     <= 5'd0;
            tag_reg     <= 32'd0;
            fld_reg     <= 32'd0;
            rem_reg     <= 32'd0;
            rate_reg    <= 32'd0;
            stereo_reg  <= 1'b0;
            sixteen_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            tag_reg     <= tag_next;
            fld_reg     <= fld_next;
            rem_reg     <= rem_next;
            rate_reg    <= rate_next;
            stereo_reg  <= stereo_next;
            sixteen_reg <= sixteen_next;
        end
    end

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last |=> phase_reg == PH_HEAD && cnt_reg == 5'd0)
        else $error("final buffer byte did not restart the parser");

    a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.has && res.kind == wavhp_pkg::EV_ERROR
        |=> phase_reg == PH_IDLE || phase_reg == PH_HEAD)
        else $error("parser kept working after an error");

    a_fmt_data: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.has && res.kind == wavhp_pkg::EV_FORMAT
        |=> phase_reg == PH_DATA && rem_reg != 32'd0)
        else $error("format result not followed by payload phase");

endmodule

// ----- rtl/wavhp_out_stage.sv -----
// wavhp_out_stage: result register facing the output channel
// depends on wavhp_pkg (result_t)
`timescale 1ns / 1ps

module wavhp_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  wavhp_pkg::result_t res,
    input  logic               out_stall,
    output logic               can_take,
    output logic               out_valid,
    output wavhp_pkg::result_t held
);

    logic               valid_reg;
    logic               valid_next;
    wavhp_pkg::result_t res_reg;

    // register is free when empty or draining this cycle
    assign can_take = !valid_reg || !out_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign held      = res_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_stall |-> !load)
        else $error("stalled result overwritten");

endmodule

// ----- verif/tb_top.sv -----
// tb_top: self-checking testbench for wav_header_parser
// a directed table of byte items, then random wave buffers, checked against a behavioral parser
// depends on wavhp_pkg and the rtl top level wav_header_parser
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_ITEMS   = 1000;
    localparam int QUIET_ITEMS    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    // parser phases of the behavioral model
    typedef enum logic [3:0] {
        PH_HEAD      = 4'd0,
        PH_FMT_HDR   = 4'd1,
        PH_FMT_SKIP  = 4'd2,
        PH_FMT_BODY  = 4'd3,
        PH_FMT_EXTRA = 4'd4,
        PH_DATA_HDR  = 4'd5,
        PH_DATA_SKIP = 4'd6,
        PH_DATA      = 4'd7,
        PH_IDLE      = 4'd8
    } parse_phase_t;

    // one byte item, with a typed-in result where one is given
    typedef struct packed {
        logic [7:0]         b;
        logic               last;
        logic               typed;
        wavhp_pkg::result_t evt;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  byte_in = 8'h00;
    logic        buffer_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  event_kind;
    logic [31:0] sample_rate;
    logic        stereo;
    logic        sixteen_bit;
    logic [31:0] payload_length;
    logic [7:0]  data_byte;
    logic        end_of_run;
    logic [3:0]  error_code;

    stim_row_t          cur_row = '0;
    stim_row_t          directed_rows[$];
    logic [7:0]         byte_q[$];
    wavhp_pkg::result_t pending_events[$];
    logic               quiet = 1'b0;
    logic               timed_out = 1'b0;
    int                 fail_count = 0;
    int                 stuck_cycles = 0;
    int                 stall_left = 0;

    // behavioral parser state
    parse_phase_t phase = PH_HEAD;
    logic [4:0]   fld_cnt = '0;
    logic [31:0]  tag_sr = '0;
    logic [31:0]  fld_sr = '0;
    logic [31:0]  remain = '0;
    logic [31:0]  held_rate = '0;
    logic         held_stereo = 1'b0;
    logic         held_sixteen = 1'b0;

    wav_header_parser dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_in        (byte_in),
        .buffer_end     (buffer_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .sample_rate    (sample_rate),
        .stereo         (stereo),
        .sixteen_bit    (sixteen_bit),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .end_of_run     (end_of_run),
        .error_code     (error_code)
    );

    // clock
    always #5 clk = ~clk;

    // error event; the parse then idles until the buffer ends
    function automatic wavhp_pkg::result_t error_event(input wavhp_pkg::error_code_t code);
        wavhp_pkg::result_t evt;
        evt = '0;
        evt.has = 1'b1;
        evt.kind = wavhp_pkg::EV_ERROR;
        evt.end_of_run = 1'b1;
        evt.code = code;
        phase = PH_IDLE;
        return evt;
    endfunction

    // shift one byte of an 8-byte chunk header, tag big-endian, size little-endian
    function automatic logic chunk_hdr_byte(input logic [7:0] b);
        if (fld_cnt < 5'd4)
            tag_sr = {tag_sr[23:0], b};
        else
            fld_sr = {b, fld_sr[31:8]};
        fld_cnt = fld_cnt + 5'd1;
        if (fld_cnt >= 5'd8)
        begin
            fld_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // one byte of a skipped region
    task automatic skip_byte(input parse_phase_t nxt);
        if (remain != 32'd0)
            remain = remain - 32'd1;
        if (remain == 32'd0)
            phase = nxt;
    endtask

    // expected parser event for one accepted byte
    task automatic parse_wav_byte(input logic [7:0] b, input logic last,
                                  output logic pred_has, output wavhp_pkg::result_t evt);
        logic [4:0]             c;
        wavhp_pkg::error_code_t trunc;
        evt = '0;
        pred_has = 1'b0;
        case (phase)
            PH_HEAD:
            begin
                tag_sr = {tag_sr[23:0], b};
                if (fld_cnt == 5'd3 && tag_sr != wavhp_pkg::TAG_RIFF)
                begin
                    evt = error_event(wavhp_pkg::ERR_NO_RIFF);
                    pred_has = 1'b1;
                end
                else if (fld_cnt >= 5'd11)
                begin
                    fld_cnt = '0;
                    if (tag_sr != wavhp_pkg::TAG_WAVE)
                    begin
                        evt = error_event(wavhp_pkg::ERR_NO_WAVE);
                        pred_has = 1'b1;
                    end
                    else
                        phase = PH_FMT_HDR;
                end
                else
                    fld_cnt = fld_cnt + 5'd1;
            end
            PH_FMT_HDR:
            begin
                if (chunk_hdr_byte(b))
                begin
                    remain = fld_sr;
                    if (tag_sr == wavhp_pkg::TAG_FMT)
                        phase = PH_FMT_BODY;
                    else if (fld_sr == 32'd0)
                    begin
                        evt = error_event(wavhp_pkg::ERR_ZERO_CHK);
                        pred_has = 1'b1;
                    end
                    else
                        phase = PH_FMT_SKIP;
                end
            end
            PH_FMT_SKIP:
                skip_byte(PH_FMT_HDR);
            PH_FMT_BODY:
            begin
                // format and channels land in tag_sr, rate then bits in fld_sr
                c = fld_cnt;
                if (c < 5'd4)
                    tag_sr = {b, tag_sr[31:8]};
                else if (c < 5'd8 || c >= 5'd14)
                    fld_sr = {b, fld_sr[31:8]};
                if (c == 5'd7)
                    held_rate = fld_sr;
                fld_cnt = fld_cnt + 5'd1;
                if (c >= 5'd15)
                begin
                    fld_cnt = '0;
                    if (tag_sr[15:0] != 16'd1)
                    begin
                        evt = error_event(wavhp_pkg::ERR_NOT_PCM);
                        pred_has = 1'b1;
                    end
                    else if (tag_sr[31:16] != 16'd1 && tag_sr[31:16] != 16'd2)
                    begin
                        evt = error_event(wavhp_pkg::ERR_CHANNELS);
                        pred_has = 1'b1;
                    end
                    else if (fld_sr[31:16] != 16'd8 && fld_sr[31:16] != 16'd16)
                    begin
                        evt = error_event(wavhp_pkg::ERR_BITS);
                        pred_has = 1'b1;
                    end
                    else
                    begin
                        held_stereo = (tag_sr[31:16] == 16'd2);
                        held_sixteen = (fld_sr[31:16] == 16'd16);
                        if (remain > 32'd16)
                        begin
                            remain = remain - 32'd16;
                            phase = PH_FMT_EXTRA;
                        end
                        else
                        begin
                            remain = '0;
                            phase = PH_DATA_HDR;
                        end
                    end
                end
            end
            PH_FMT_EXTRA:
                skip_byte(PH_DATA_HDR);
            PH_DATA_HDR:
            begin
                if (chunk_hdr_byte(b))
                begin
                    if (tag_sr == wavhp_pkg::TAG_DATA)
                    begin
                        if (fld_sr == 32'd0)
                            evt = error_event(wavhp_pkg::ERR_ZERO_DATA);
                        else
                        begin
                            evt.has = 1'b1;
                            evt.kind = wavhp_pkg::EV_FORMAT;
                            evt.sample_rate = held_rate;
                            evt.stereo = held_stereo;
                            evt.sixteen_bit = held_sixteen;
                            evt.payload_length = fld_sr;
                            evt.code = wavhp_pkg::ERR_NONE;
                            remain = fld_sr;
                            phase = PH_DATA;
                        end
                        pred_has = 1'b1;
                    end
                    else if (fld_sr == 32'd0)
                    begin
                        evt = error_event(wavhp_pkg::ERR_ZERO_CHK);
                        pred_has = 1'b1;
                    end
                    else
                    begin
                        remain = fld_sr;
                        phase = PH_DATA_SKIP;
                    end
                end
            end
            PH_DATA_SKIP:
                skip_byte(PH_DATA_HDR);
            PH_DATA:
            begin
                evt.has = 1'b1;
                evt.kind = wavhp_pkg::EV_DATA;
                evt.data_byte = b;
                evt.code = wavhp_pkg::ERR_NONE;
                pred_has = 1'b1;
                if (remain != 32'd0)
                    remain = remain - 32'd1;
                if (remain == 32'd0)
                begin
                    evt.end_of_run = 1'b1;
                    phase = PH_IDLE;
                end
            end
            default:
            begin
            end
        endcase

        // final byte: an unfinished parse turns into an error, then restart
        if (last)
        begin
            case (phase)
                PH_FMT_HDR, PH_FMT_SKIP:   trunc = wavhp_pkg::ERR_NO_FMT;
                PH_DATA_HDR, PH_DATA_SKIP: trunc = wavhp_pkg::ERR_NO_DATA;
                PH_HEAD, PH_FMT_BODY, PH_FMT_EXTRA, PH_DATA:
                    trunc = wavhp_pkg::ERR_TRUNC;
                default:                   trunc = wavhp_pkg::ERR_NONE;
            endcase
            if (trunc != wavhp_pkg::ERR_NONE)
            begin
                evt = error_event(trunc);
                pred_has = 1'b1;
            end
            phase = PH_HEAD;
            fld_cnt = '0;
            tag_sr = '0;
            fld_sr = '0;
            remain = '0;
            held_rate = '0;
            held_stereo = 1'b0;
            held_sixteen = 1'b0;
        end
    endtask

    // failure report, limited in number
    task automatic report_fail(input string what, input wavhp_pkg::result_t want,
                               input wavhp_pkg::result_t seen);
        fail_count = fail_count + 1;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("%0t %s", $time, what);
            $display("  exp: kind=%0d rate=%h st=%b s16=%b len=%h byte=%h eor=%b err=%0d",
                     want.kind, want.sample_rate, want.stereo, want.sixteen_bit,
                     want.payload_length, want.data_byte, want.end_of_run, want.code);
            $display("  got: kind=%0d rate=%h st=%b s16=%b len=%h byte=%h eor=%b err=%0d",
                     seen.kind, seen.sample_rate, seen.stereo, seen.sixteen_bit,
                     seen.payload_length, seen.data_byte, seen.end_of_run, seen.code);
        end
    endtask

    // prediction on input acceptance, checking on output acceptance, watchdog count
    always @(posedge clk)
    begin : scoreboard
        logic               pred_has;
        wavhp_pkg::result_t pred_evt;
        wavhp_pkg::result_t seen;
        wavhp_pkg::result_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            parse_wav_byte(cur_row.b, cur_row.last, pred_has, pred_evt);
            if (cur_row.typed)
                pending_events.push_back(cur_row.evt);
            else if (pred_has)
                pending_events.push_back(pred_evt);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            seen.has = 1'b1;
            seen.kind = wavhp_pkg::event_kind_t'(event_kind);
            seen.sample_rate = sample_rate;
            seen.stereo = stereo;
            seen.sixteen_bit = sixteen_bit;
            seen.payload_length = payload_length;
            seen.data_byte = data_byte;
            seen.end_of_run = end_of_run;
            seen.code = wavhp_pkg::error_code_t'(error_code);
            if (pending_events.size() == 0)
                report_fail("result with nothing expected", '0, seen);
            else
            begin
                want = pending_events.pop_front();
                if (seen !== want)
                    report_fail("result mismatch", want, seen);
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // receiver stalls in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 9);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // offer one item from a falling edge and hold it until accepted
    task automatic send_item(input stim_row_t row);
        int gap;
        if (!quiet && $urandom_range(0, 11) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        byte_in <= row.b;
        buffer_end <= row.last;
        cur_row <= row;
        @(posedge clk);
        while (!(in_valid && !in_stall))
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold off the sender until every expected result has come out
    task automatic wait_for_drain;
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_events.size() != 0);
    endtask

    task automatic add_row(input logic [7:0] b, input logic last,
                           input wavhp_pkg::error_code_t code);
        stim_row_t row;
        row = '0;
        row.b = b;
        row.last = last;
        row.typed = (code != wavhp_pkg::ERR_NONE);
        if (code != wavhp_pkg::ERR_NONE)
        begin
            row.evt.has = 1'b1;
            row.evt.kind = wavhp_pkg::EV_ERROR;
            row.evt.end_of_run = 1'b1;
            row.evt.code = code;
        end
        directed_rows.push_back(row);
    endtask

    task automatic put_tag(input logic [31:0] tag);
        byte_q.push_back(tag[31:24]);
        byte_q.push_back(tag[23:16]);
        byte_q.push_back(tag[15:8]);
        byte_q.push_back(tag[7:0]);
    endtask

    task automatic put_le16(input logic [15:0] h);
        byte_q.push_back(h[7:0]);
        byte_q.push_back(h[15:8]);
    endtask

    task automatic put_le32(input logic [31:0] w);
        put_le16(w[15:0]);
        put_le16(w[31:16]);
    endtask

    // zero to two small chunks to skip; other_tag is the tag sought in the other search
    task automatic put_junk_chunks(input logic [31:0] other_tag);
        int          n;
        int          sz;
        logic [31:0] tag;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n)
        begin
            tag = ($urandom_range(0, 3) == 0) ? other_tag : $urandom;
            sz = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
            put_tag(tag);
            put_le32(32'(sz));
            repeat (sz) byte_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin : main
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        fork
            begin : stimulus
                int          rand_sent;
                int          nbuf;
                int          sel;
                int          plen;
                int          cut;
                logic [31:0] fmt_size;
                logic [31:0] data_len;
                stim_row_t   row;

                // directed: truncation, bad tags, bytes ignored after an error
                add_row(8'h00, 1'b1, wavhp_pkg::ERR_TRUNC);
                add_row("R", 1'b0, wavhp_pkg::ERR_NONE);
                add_row("I", 1'b0, wavhp_pkg::ERR_NONE);
                add_row("F", 1'b0, wavhp_pkg::ERR_NONE);
                add_row("X", 1'b0, wavhp_pkg::ERR_NO_RIFF);
                add_row(8'hFF, 1'b1, wavhp_pkg::ERR_NONE);
                add_row("R", 1'b0, wavhp_pkg::ERR_NONE);
                add_row("I", 1'b0, wavhp_pkg::ERR_NONE);
                add_row("F", 1'b0, wavhp_pkg::ERR_NONE);
                add_row("F", 1'b0, wavhp_pkg::ERR_NONE);
                add_row(8'hFF, 1'b0, wavhp_pkg::ERR_NONE);
                add_row(8'hFF, 1'b0, wavhp_pkg::ERR_NONE);
                add_row(8'hFF, 1'b0, wavhp_pkg::ERR_NONE);
                add_row(8'hFF, 1'b0, wavhp_pkg::ERR_NONE);
                add_row("W", 1'b0, wavhp_pkg::ERR_NONE);
                add_row("A", 1'b0, wavhp_pkg::ERR_NONE);
                add_row("V", 1'b0, wavhp_pkg::ERR_NONE);
                add_row("X", 1'b0, wavhp_pkg::ERR_NO_WAVE);
                add_row(8'h00, 1'b1, wavhp_pkg::ERR_NONE);
                add_row("R", 1'b0, wavhp_pkg::ERR_NONE);
                add_row("I", 1'b0, wavhp_pkg::ERR_NONE);
                add_row("F", 1'b1, wavhp_pkg::ERR_TRUNC);
                foreach (directed_rows[i])
                    send_item(directed_rows[i]);

                // random buffers, mostly well formed with random content
                rand_sent = 0;
                nbuf = 0;
                while (rand_sent < RANDOM_ITEMS)
                begin
                    byte_q.delete();
                    sel = $urandom_range(0, 99);
                    if (sel < 6)
                    begin
                        repeat ($urandom_range(1, 24))
                            byte_q.push_back(8'($urandom_range(0, 255)));
                    end
                    else
                    begin
                        // riff header
                        put_tag(($urandom_range(0, 32) == 0) ? $urandom : wavhp_pkg::TAG_RIFF);
                        put_le32($urandom);
                        put_tag(($urandom_range(0, 32) == 0) ? $urandom : wavhp_pkg::TAG_WAVE);
                        put_junk_chunks(wavhp_pkg::TAG_DATA);

                        // fmt chunk, sometimes short, sometimes with extra bytes
                        sel = $urandom_range(0, 19);
                        if (sel < 14)
                            fmt_size = 32'd16;
                        else if (sel < 17)
                            fmt_size = $urandom_range(17, 24);
                        else
                            fmt_size = $urandom_range(0, 15);
                        put_tag(wavhp_pkg::TAG_FMT);
                        put_le32(fmt_size);
                        put_le16(16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                                 : 1));
                        put_le16(16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                                 : $urandom_range(1, 2)));
                        put_le32($urandom);
                        put_le32($urandom);
                        put_le16(16'($urandom_range(0, 65535)));
                        if ($urandom_range(0, 9) == 0)
                            put_le16(16'($urandom_range(0, 65535)));
                        else
                            put_le16(($urandom_range(0, 1) == 0) ? 16'd8 : 16'd16);
                        if (fmt_size > 32'd16)
                            repeat (fmt_size - 32'd16)
                                byte_q.push_back(8'($urandom_range(0, 255)));
                        put_junk_chunks(wavhp_pkg::TAG_FMT);

                        // data chunk: zero, oversized and cut short, or small and complete
                        sel = $urandom_range(0, 99);
                        if (sel < 4)
                        begin
                            data_len = '0;
                            plen = 0;
                        end
                        else if (sel < 12)
                        begin
                            data_len = $urandom | 32'h0000_1000;
                            plen = $urandom_range(0, 10);
                        end
                        else
                        begin
                            data_len = $urandom_range(1, 12);
                            plen = int'(data_len + $urandom_range(0, 3));
                        end
                        put_tag(wavhp_pkg::TAG_DATA);
                        put_le32(data_len);
                        repeat (plen) byte_q.push_back(8'($urandom_range(0, 255)));

                        // broken buffers: cut short or one byte replaced
                        sel = $urandom_range(0, 99);
                        if (sel < 8)
                        begin
                            cut = $urandom_range(1, byte_q.size());
                            byte_q = byte_q[0:cut-1];
                        end
                        else if (sel < 14)
                            byte_q[$urandom_range(0, byte_q.size() - 1)] =
                                8'($urandom_range(0, 255));
                    end

                    // every fifth buffer starts only once the block has drained
                    if (nbuf % 5 == 4)
                        wait_for_drain();
                    quiet = (rand_sent >= RANDOM_ITEMS - QUIET_ITEMS);
                    foreach (byte_q[i])
                    begin
                        row = '0;
                        row.b = byte_q[i];
                        row.last = (i == byte_q.size() - 1);
                        send_item(row);
                    end
                    rand_sent = rand_sent + byte_q.size();
                    nbuf = nbuf + 1;
                end

                // drain, then let the pipeline settle
                wait_for_drain();
                repeat (8) @(negedge clk);
            end
            begin : watchdog
                wait (stuck_cycles >= WATCHDOG_LIMIT);
                timed_out = 1'b1;
                $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            end
        join_any
        disable fork;
        if (!timed_out && fail_count == 0 && pending_events.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
